// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the date/time set editor.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");
// condition implies consequence in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication violated");
// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== hw/rtl/cdts_pkg.sv =====
// Package for the date/time set editor: types, command codes, reset values
// and calendar helper functions. No dependencies.
package cdts_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int CUR_W    = 2;
    localparam int ORD_W    = 2;
    localparam int MODE_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam logic [YEAR_W-1:0]  YEAR_TOP     = 12'd4095;
    localparam logic [YEAR_W-1:0]  YEAR_LO_RST  = 12'd2000;
    localparam logic [YEAR_W-1:0]  YEAR_HI_RST  = 12'd2099;
    localparam logic [MONTH_W-1:0] MONTH_LAST   = 4'd12;
    localparam logic [HOUR_W-1:0]  HOUR_LAST    = 5'd23;
    localparam logic [MIN_W-1:0]   MIN_LAST     = 6'd59;
    localparam logic [SEC_W-1:0]   SEC_LAST     = 6'd59;
    localparam logic [CUR_W-1:0]   CUR_LAST     = 2'd2;

    // command codes
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD      = 4'd0,
        MODE_TCUR_LEFT = 4'd1,
        MODE_TCUR_RGT  = 4'd2,
        MODE_TIME_UP   = 4'd3,
        MODE_TIME_DOWN = 4'd4,
        MODE_DCUR_LEFT = 4'd5,
        MODE_DCUR_RGT  = 4'd6,
        MODE_DATE_UP   = 4'd7,
        MODE_DATE_DOWN = 4'd8
    } t_mode;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATE_ORDER = 2'd0,
        CFG_YEAR_LO    = 2'd1,
        CFG_YEAR_HI    = 2'd2
    } t_cfg_idx;

    // date order codes
    typedef enum logic [ORD_W-1:0] {
        ORD_YMD = 2'd0,
        ORD_MDY = 2'd1,
        ORD_DMY = 2'd2
    } t_date_order;

    // time cursor positions
    typedef enum logic [CUR_W-1:0] {
        TCUR_HOUR   = 2'd0,
        TCUR_MINUTE = 2'd1,
        TCUR_SECOND = 2'd2
    } t_time_pos;

    // date field selected by the date cursor
    typedef enum logic [1:0] {
        FLD_YEAR  = 2'd0,
        FLD_MONTH = 2'd1,
        FLD_DAY   = 2'd2
    } t_date_field;

    typedef struct packed {
        logic [ORD_W-1:0]  date_order;
        logic [YEAR_W-1:0] year_lo;
        logic [YEAR_W-1:0] year_hi;
    } t_cfg;

    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [MODE_W-1:0]  mode;
    } t_in_item;

    typedef struct packed {
        logic [CUR_W-1:0]   dcur;
        logic [CUR_W-1:0]   tcur;
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_edit_state;

    localparam t_edit_state STATE_RST = '{
        dcur: '0, tcur: '0, second: '0, minute: '0, hour: '0,
        day: 5'd1, month: 4'd1, year: YEAR_LO_RST
    };

    // Gregorian leap test; year/100 and year/400 via q = y/4 and q/25
    // (q * 1311 >> 15 is exact for q below 1024)
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [9:0]  q;
        logic [20:0] prod;
        logic [5:0]  quo;
        logic [10:0] quo25;
        logic [9:0]  rem;
        q     = y[YEAR_W-1:2];
        prod  = q * 11'd1311;
        quo   = prod[20:15];
        quo25 = quo * 5'd25;
        rem   = q - quo25[9:0];
        return (y[1:0] == 2'd0) && ((rem != 10'd0) || (quo[1:0] == 2'd0));
    endfunction

    // length of a month; invalid months count as January
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0]  y);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:    len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/cdts_update.sv =====
// Next-state logic of the date/time set editor: applies one command to the
// edit copy and cursors. Depends on cdts_pkg.
module cdts_update (
    input  cdts_pkg::t_cfg        i_cfg,
    input  cdts_pkg::t_edit_state i_state,
    input  cdts_pkg::t_in_item    i_item,
    output cdts_pkg::t_edit_state o_state,
    output logic                  o_rewrite
);
    import cdts_pkg::*;

    t_date_field      w_fld;
    logic [DAY_W-1:0] w_day_src;
    logic [DAY_W-1:0] w_len;
    logic             w_clamp;
    logic             w_day_wrap;
    logic             w_up;

    // date cursor to field, per date order (unused order code acts as YMD)
    always_comb begin
        w_fld = FLD_YEAR;
        unique case (i_cfg.date_order)
            ORD_MDY: begin
                unique case (i_state.dcur)
                    2'd1:    w_fld = FLD_DAY;
                    2'd2:    w_fld = FLD_YEAR;
                    default: w_fld = FLD_MONTH;
                endcase
            end
            ORD_DMY: begin
                unique case (i_state.dcur)
                    2'd1:    w_fld = FLD_MONTH;
                    2'd2:    w_fld = FLD_YEAR;
                    default: w_fld = FLD_DAY;
                endcase
            end
            default: begin
                unique case (i_state.dcur)
                    2'd1:    w_fld = FLD_MONTH;
                    2'd2:    w_fld = FLD_DAY;
                    default: w_fld = FLD_YEAR;
                endcase
            end
        endcase
    end

    // command decode: year, month, time and cursors; day settled below
    always_comb begin
        o_state    = i_state;
        o_rewrite  = 1'b0;
        w_day_src  = i_state.day;
        w_clamp    = 1'b0;
        w_day_wrap = 1'b0;
        w_up       = (i_item.mode == MODE_TIME_UP) || (i_item.mode == MODE_DATE_UP);
        case (i_item.mode) inside
            MODE_LOAD: begin
                if (i_item.year > i_cfg.year_hi) begin
                    o_state.year  = i_cfg.year_lo;
                    o_state.month = 4'd1;
                    w_day_src     = 5'd1;
                    o_rewrite     = 1'b1;
                end else begin
                    o_state.year  = i_item.year;
                    o_state.month = (i_item.month == 4'd0 || i_item.month > MONTH_LAST)
                                    ? 4'd1 : i_item.month;
                    w_day_src     = i_item.day;
                end
                w_clamp        = 1'b1;
                o_state.hour   = (i_item.hour > HOUR_LAST) ? HOUR_LAST : i_item.hour;
                o_state.minute = (i_item.minute > MIN_LAST) ? MIN_LAST : i_item.minute;
                o_state.second = (i_item.second > SEC_LAST) ? SEC_LAST : i_item.second;
            end
            MODE_TCUR_LEFT: o_state.tcur = (i_state.tcur == 2'd0 || i_state.tcur > CUR_LAST)
                                           ? CUR_LAST : i_state.tcur - 2'd1;
            MODE_TCUR_RGT:  o_state.tcur = (i_state.tcur >= CUR_LAST)
                                           ? 2'd0 : i_state.tcur + 2'd1;
            MODE_DCUR_LEFT: o_state.dcur = (i_state.dcur == 2'd0 || i_state.dcur > CUR_LAST)
                                           ? CUR_LAST : i_state.dcur - 2'd1;
            MODE_DCUR_RGT:  o_state.dcur = (i_state.dcur >= CUR_LAST)
                                           ? 2'd0 : i_state.dcur + 2'd1;
            MODE_TIME_UP, MODE_TIME_DOWN: begin
                case (i_state.tcur)
                    TCUR_HOUR: begin
                        if (w_up) o_state.hour = (i_state.hour >= HOUR_LAST)
                                                 ? 5'd0 : i_state.hour + 5'd1;
                        else      o_state.hour = (i_state.hour == 5'd0 ||
                                                  i_state.hour > HOUR_LAST)
                                                 ? HOUR_LAST : i_state.hour - 5'd1;
                    end
                    TCUR_MINUTE: begin
                        if (w_up) o_state.minute = (i_state.minute >= MIN_LAST)
                                                   ? 6'd0 : i_state.minute + 6'd1;
                        else      o_state.minute = (i_state.minute == 6'd0 ||
                                                    i_state.minute > MIN_LAST)
                                                   ? MIN_LAST : i_state.minute - 6'd1;
                    end
                    TCUR_SECOND: begin
                        if (w_up) o_state.second = (i_state.second >= SEC_LAST)
                                                   ? 6'd0 : i_state.second + 6'd1;
                        else      o_state.second = (i_state.second == 6'd0 ||
                                                    i_state.second > SEC_LAST)
                                                   ? SEC_LAST : i_state.second - 6'd1;
                    end
                    default: ;
                endcase
            end
            MODE_DATE_UP, MODE_DATE_DOWN: begin
                case (w_fld)
                    FLD_YEAR: begin
                        if (w_up) o_state.year = (i_state.year == i_cfg.year_hi ||
                                                  i_state.year == YEAR_TOP)
                                                 ? i_cfg.year_lo : i_state.year + 12'd1;
                        else      o_state.year = (i_state.year == i_cfg.year_lo ||
                                                  i_state.year == 12'd0)
                                                 ? i_cfg.year_hi : i_state.year - 12'd1;
                        w_clamp = 1'b1;
                    end
                    FLD_MONTH: begin
                        if (w_up) o_state.month = (i_state.month >= MONTH_LAST)
                                                  ? 4'd1 : i_state.month + 4'd1;
                        else      o_state.month = (i_state.month <= 4'd1)
                                                  ? MONTH_LAST : i_state.month - 4'd1;
                        w_clamp = 1'b1;
                    end
                    default: w_day_wrap = 1'b1;
                endcase
            end
            default: ;
        endcase

        // one month-length lookup on the resulting year and month
        w_len = days_in(o_state.month, o_state.year);
        if (w_clamp) begin
            if (w_day_src > w_len)       o_state.day = w_len;
            else if (w_day_src == 5'd0)  o_state.day = 5'd1;
            else                         o_state.day = w_day_src;
        end else if (w_day_wrap) begin
            if (w_up) o_state.day = (i_state.day >= w_len) ? 5'd1 : i_state.day + 5'd1;
            else      o_state.day = (i_state.day <= 5'd1) ? w_len : i_state.day - 5'd1;
        end
    end

endmodule

// ===== hw/rtl/clock_date_time_set_editor_top.sv =====
// Date/time set editor, top level: stream ports, configuration registers,
// input register, edit state and result register. Depends on cdts_pkg,
// cdts_update and assert_macros.svh.
//
// Each input item is one editing command (load from the running clock, move
// the time or date cursor, raise or lower the field under a cursor) and
// yields exactly one result item carrying the edit copy and both cursors
// after that command. One item is taken per clock cycle while the result stream
// does not stall; a result is shown on the result stream once its item has
// passed the input register and the result register has loaded it, and the
// result register loads only when it is empty or its result is being taken.
// While a result waits on a stalled output, one more item can still be taken
// into an empty input register; input then stalls until the result is taken.
// The rate is set by the edit-state registers, which load one new state per accepted command.
// Configuration is written through a plain write port and should only change
// while no command is in flight.
`include "assert_macros.svh"
module clock_date_time_set_editor_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] mode, [15:4] load_year, [19:16] load_month, [24:20] load_day,
    // [29:25] load_hour, [35:30] load_minute, [41:36] load_second, rest zero
    input  logic [cdts_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [11:0] edit_year, [15:12] edit_month, [20:16] edit_day,
    // [25:21] edit_hour, [31:26] edit_minute, [37:32] edit_second,
    // [39:38] time_field_pos, [41:40] date_field_pos, [42] clock_rewrite,
    // rest zero
    output logic [cdts_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [cdts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cdts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import cdts_pkg::*;

    t_cfg        r_cfg;
    t_edit_state r_state;
    t_edit_state w_next;
    t_edit_state r_out;
    t_in_item    r_in;
    logic        r_in_valid;
    logic        r_out_valid;
    logic        r_out_rewrite;
    logic        w_rewrite;
    logic        w_adv;
    logic        w_fire;
    logic        w_cur_ok;
    logic        w_date_ok;
    logic        w_time_ok;
    logic        w_jan1;

    // pipeline control: result register frees when empty or taken
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.date_order <= ORD_YMD;
            r_cfg.year_lo    <= YEAR_LO_RST;
            r_cfg.year_hi    <= YEAR_HI_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DATE_ORDER: r_cfg.date_order <= i_cfg_data[ORD_W-1:0];
                CFG_YEAR_LO:    r_cfg.year_lo    <= i_cfg_data[YEAR_W-1:0];
                CFG_YEAR_HI:    r_cfg.year_hi    <= i_cfg_data[YEAR_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata[$bits(t_in_item)-1:0];
        end
    end

    cdts_update u_update (
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .i_item    (r_in),
        .o_state   (w_next),
        .o_rewrite (w_rewrite)
    );

    // edit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else if (w_fire) begin
            r_state <= w_next;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out         <= w_next;
            r_out_rewrite <= w_rewrite;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_edit_state) - 1){1'b0}},
                            r_out_rewrite, r_out};

    // range terms for the checks
    assign w_cur_ok  = (r_state.tcur <= CUR_LAST) && (r_state.dcur <= CUR_LAST);
    assign w_date_ok = (r_state.month >= 4'd1) && (r_state.month <= MONTH_LAST) &&
                       (r_state.day >= 5'd1) &&
                       (r_state.day <= days_in(r_state.month, r_state.year));
    assign w_time_ok = (r_state.hour <= HOUR_LAST) && (r_state.minute <= MIN_LAST) &&
                       (r_state.second <= SEC_LAST);
    assign w_jan1    = (r_out.month == 4'd1) && (r_out.day == 5'd1);

    // checks
    `ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, r_out_valid)
    `ASSERT_ALWAYS(a_cursor_range, i_clk, i_rst_n, w_cur_ok)
    `ASSERT_ALWAYS(a_date_range, i_clk, i_rst_n, w_date_ok)
    `ASSERT_ALWAYS(a_time_range, i_clk, i_rst_n, w_time_ok)
    `ASSERT_IMPLIES(a_rewrite_jan1, i_clk, i_rst_n, r_out_valid && r_out_rewrite, w_jan1)

endmodule
